### sv/gpcl_pkg.sv
package gpcl_pkg;

	localparam int unsigned PIN_COUNT_DEF = 16;
	localparam int unsigned KEY_BIT       = 16;
	localparam logic [31:0] CFG_RESET     = 32'h4444_4444;

	// bus commands
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// register selectors
	localparam logic [2:0] REG_CFG_LO = 3'd0;
	localparam logic [2:0] REG_CFG_HI = 3'd1;
	localparam logic [2:0] REG_IDR    = 3'd2;
	localparam logic [2:0] REG_ODR    = 3'd3;
	localparam logic [2:0] REG_LOCK   = 3'd4;

	// lock key sequencer
	typedef enum logic [3:0] {
		KEY_IDLE  = 4'b0001,
		KEY_ONE   = 4'b0010,
		KEY_TWO   = 4'b0100,
		KEY_ARMED = 4'b1000
	} gpcl_key_t;

	typedef struct packed {
		logic        command;
		logic [2:0]  reg_select;
		logic [31:0] write_data;
		logic [15:0] pin_levels;
	} gpcl_access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] pin_drive;
		logic        lock_active;
	} gpcl_result_t;

	// nibble mask covering the locked pins of one configuration word
	function automatic logic [31:0] frozen_fields(input logic [7:0] mask);
		logic [31:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (mask[i]) begin
				m[4*i +: 4] = 4'hf;
			end
		end
		return m;
	endfunction

endpackage

### sv/gpcl_regs.sv
module gpcl_regs #(
	parameter int unsigned PIN_COUNT = gpcl_pkg::PIN_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  gpcl_pkg::gpcl_access_t acc,
	output gpcl_pkg::gpcl_result_t res
);
	import gpcl_pkg::*;

	localparam logic [15:0] PIN_MASK = 16'((33'h1 << PIN_COUNT) - 33'h1);

	logic [31:0] cfg_lo_q, cfg_hi_q;
	logic [15:0] odr_q, lock_mask_q;
	gpcl_key_t   phase_q;
	logic        locked_q;

	logic [31:0] cfg_lo_d, cfg_hi_d;
	logic [15:0] odr_d, lock_mask_d;
	gpcl_key_t   phase_d;
	logic        locked_d;

	logic [31:0] keep_lo, keep_hi, rd;
	logic [15:0] wr_mask;
	logic        key, same;

	assign keep_lo = locked_q ? frozen_fields(lock_mask_q[7:0])  : '0;
	assign keep_hi = locked_q ? frozen_fields(lock_mask_q[15:8]) : '0;
	assign wr_mask = acc.write_data[15:0] & PIN_MASK;
	assign key     = acc.write_data[KEY_BIT];
	assign same    = (wr_mask == lock_mask_q);

	always_comb begin
		cfg_lo_d    = cfg_lo_q;
		cfg_hi_d    = cfg_hi_q;
		odr_d       = odr_q;
		lock_mask_d = lock_mask_q;
		phase_d     = phase_q;
		locked_d    = locked_q;
		rd          = '0;
		if (acc.command == CMD_WRITE) begin
			case (acc.reg_select)
				REG_CFG_LO: cfg_lo_d = (cfg_lo_q & keep_lo) | (acc.write_data & ~keep_lo);
				REG_CFG_HI: cfg_hi_d = (cfg_hi_q & keep_hi) | (acc.write_data & ~keep_hi);
				REG_ODR:    odr_d = acc.write_data[15:0] & PIN_MASK;
				REG_LOCK: begin
					if (!locked_q) begin
						if (phase_q == KEY_ONE && !key && same) begin
							phase_d = KEY_TWO;
						end else if (phase_q == KEY_TWO && key && same) begin
							phase_d = KEY_ARMED;
						end else begin
							phase_d = key ? KEY_ONE : KEY_IDLE;
						end
						lock_mask_d = wr_mask;
					end
				end
				default: ;
			endcase
		end else begin
			case (acc.reg_select)
				REG_CFG_LO: rd = cfg_lo_q;
				REG_CFG_HI: rd = cfg_hi_q;
				REG_IDR:    rd = {16'h0, acc.pin_levels & PIN_MASK};
				REG_ODR:    rd = {16'h0, odr_q};
				REG_LOCK: begin
					rd = {15'h0, locked_q, lock_mask_q};
					if (!locked_q && phase_q == KEY_ARMED) begin
						locked_d = 1'b1;
						phase_d  = KEY_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	assign res.read_data   = rd;
	assign res.pin_drive   = odr_d;
	assign res.lock_active = locked_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_lo_q    <= CFG_RESET;
			cfg_hi_q    <= CFG_RESET;
			odr_q       <= '0;
			lock_mask_q <= '0;
			phase_q     <= KEY_IDLE;
			locked_q    <= 1'b0;
		end else if (en) begin
			cfg_lo_q    <= cfg_lo_d;
			cfg_hi_q    <= cfg_hi_d;
			odr_q       <= odr_d;
			lock_mask_q <= lock_mask_d;
			phase_q     <= phase_d;
			locked_q    <= locked_d;
		end
	end

	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |=> locked_q)
		else $error("lock released without reset");

	a_mask_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |=> $stable(lock_mask_q))
		else $error("lock mask changed while locked");

	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lock_mask_q & ~PIN_MASK) == 16'h0 && (odr_q & ~PIN_MASK) == 16'h0)
		else $error("bits set beyond the implemented pins");

	a_locked_idle: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> phase_q == KEY_IDLE)
		else $error("key sequencer active after lock");

endmodule

### sv/gpio_port_config_lock_core.sv
// GPIO port with configuration lock. Each input transaction is one register
// access (read or write of config low/high, input data, output data or lock);
// each produces exactly one output transaction carrying the read data, the
// output data word after the access and the lock status. The core takes one
// transaction per clock unless out_stall holds a result in the result register:
// an input register (_s1) feeds a single pass of access logic into the result
// register (_s2), where the result is presented and held until it is taken.
// Register state updates when an access moves from the input register into
// the result register. out_stall reaches in_stall combinationally, so a full
// pipeline still accepts a new transaction in the same cycle the held result
// is taken. Once the lock key sequence
// (write bit 16 = 1, 0, 1 with an unchanged pin mask, then read) completes,
// configuration fields of masked pins and the lock register hold until reset.
module gpio_port_config_lock_core #(
	parameter int unsigned PIN_COUNT = gpcl_pkg::PIN_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [2:0]  reg_select,
	input  logic [31:0] write_data,
	input  logic [15:0] pin_levels,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [15:0] pin_drive,
	output logic        lock_active
);
	import gpcl_pkg::*;

	gpcl_access_t acc_s1;
	logic         valid_s1;
	gpcl_result_t res_s2, res_comb;
	logic         valid_s2;

	logic adv_s2;   // result register free or being emptied this cycle
	logic move;     // access leaves the input register and commits
	logic accept;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign move     = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign accept   = in_valid && !in_stall;

	// capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_s1.command    <= command;
			acc_s1.reg_select <= reg_select;
			acc_s1.write_data <= write_data;
			acc_s1.pin_levels <= pin_levels;
		end
	end

	// register file and lock sequencer; commits only on move
	gpcl_regs #(
		.PIN_COUNT(PIN_COUNT)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (move),
		.acc    (acc_s1),
		.res    (res_comb)
	);

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid   = valid_s2;
	assign read_data   = res_s2.read_data;
	assign pin_drive   = res_s2.pin_drive;
	assign lock_active = res_s2.lock_active;

endmodule
